@@ rtl/pstree_pkg.sv @@
// Shared types and codes of the prioritized sum-tree sampler.
package pstree_pkg;

    localparam int SLOT_W = 10;
    localparam int MASS_W = 48;
    localparam int PAY_W  = 32;
    localparam int PRI_W  = 32;

    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_UPDATE   = 3'd1;
    localparam logic [2:0] REQ_GET_MASS = 3'd2;
    localparam logic [2:0] REQ_GET_FRAC = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_UPDATE,
        OP_GET_MASS,
        OP_GET_FRAC,
        OP_READ
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_FRAC,
        ST_FSUM,
        ST_DESC,
        ST_RDAT,
        ST_LEAF,
        ST_UP,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [MASS_W-1:0]  weight;
        logic [PAY_W-1:0]   payload;
    } req_t;

    typedef struct packed {
        logic               evicted_valid;
        logic [PAY_W-1:0]   evicted_payload;
        logic [PRI_W-1:0]   evicted_priority;
        logic [SLOT_W-1:0]  found_index;
        logic [PAY_W-1:0]   found_payload;
        logic [PRI_W-1:0]   found_priority;
        logic [MASS_W-1:0]  total_mass;
        logic               bad_index;
    } result_t;

endpackage

@@ rtl/prioritized_sum_tree_sampler_core.sv @@
// Top level of the prioritized sum-tree sampler.
// Usage: one request beat on the s_axis channel gives exactly one result
// beat on the m_axis channel. s_axis_tuser carries the request kind
// (insert, update, get by mass, get by fraction, read); s_axis_tdata the
// slot, weight and payload. m_axis_tuser carries the evicted and bad-index
// flags, m_axis_tdata the evicted leaf, the found leaf and the root mass.
// A two-entry request queue takes beats while the sequencer works and while
// a result waits in the output register.
// Insert and update write the leaf, then add the delta on the tree memory's
// upward delta walk, one tree level per cycle; gets descend from the root, a
// fraction first taking a multiply step and a sum step. The sequencer takes a
// new request from the queue only once the result of the last one has left
// the output register.
// After reset the whole tree memory is cleared, during which no request is
// taken from the queue. A stalled m_axis holds the result and the sequencer
// waits; the queue keeps taking beats until full.
module prioritized_sum_tree_sampler_core
    import pstree_pkg::*;
#(
    parameter int CAPACITY      = 1024,
    parameter int PRIORITY_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot [9:0], weight [57:10], payload [89:58]
    input  logic [95:0]  s_axis_tdata,
    // req_type [2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // evicted_payload [31:0], evicted_priority [63:32], found_index [73:64],
    // found_payload [105:74], found_priority [137:106], total_mass [185:138]
    output logic [191:0] m_axis_tdata,
    // evicted_valid [0], bad_index [1]
    output logic [1:0]   m_axis_tuser
);

    logic    q_valid;
    logic    q_pop;
    req_t    q_data;
    result_t res;

    pstree_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_type    (s_axis_tuser),
        .in_slot    (s_axis_tdata[9:0]),
        .in_weight  (s_axis_tdata[57:10]),
        .in_payload (s_axis_tdata[89:58]),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data)
    );

    pstree_back #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {6'b0, res.total_mass, res.found_priority, res.found_payload,
                           res.found_index, res.evicted_priority, res.evicted_payload};
    assign m_axis_tuser = {res.bad_index, res.evicted_valid};

endmodule

@@ rtl/pstree_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pstree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pstree_front.sv @@
// Request intake: decode the request kind and queue it for the sequencer.
module pstree_front
    import pstree_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_type,
    input  logic [SLOT_W-1:0] in_slot,
    input  logic [MASS_W-1:0] in_weight,
    input  logic [PAY_W-1:0]  in_payload,
    output logic              q_valid,
    input  logic              q_pop,
    output req_t              q_data
);

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    op_t        op;

    always_comb begin
        unique case (in_type)
            REQ_INSERT:   op = OP_INSERT;
            REQ_UPDATE:   op = OP_UPDATE;
            REQ_GET_MASS: op = OP_GET_MASS;
            REQ_GET_FRAC: op = OP_GET_FRAC;
            REQ_READ:     op = OP_READ;
            default:      op = OP_NONE;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{op: op, slot: in_slot, weight: in_weight,
                                     payload: in_payload};
        end
    end

endmodule

@@ rtl/pstree_back.sv @@
// Tree sequencer: leaf updates, upward delta walk, descent and result register.
module pstree_back
    import pstree_pkg::*;
#(
    parameter int CAPACITY      = 1024,
    parameter int PRIORITY_BITS = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_pop,
    input  req_t    q_data,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int LW     = $clog2(CAPACITY);
    localparam int LEAVES = 1 << LW;
    localparam int AW     = LW + 1;
    localparam int FW     = LW + 1;
    localparam int CMPW   = (FW > SLOT_W) ? FW : SLOT_W;
    localparam logic [MASS_W-1:0] PRI_MAX =
        MASS_W'((65'(1) << PRIORITY_BITS) - 65'(1));

    state_t state_reg, state_next;

    req_t              cur_reg;
    logic [LW-1:0]     idx_reg;
    logic [AW-1:0]     node_reg;
    logic [AW-1:0]     clr_reg;
    logic [MASS_W-1:0] delta_reg;
    logic [MASS_W-1:0] target_reg;
    logic [MASS_W-1:0] root_reg;
    logic [63:0]       prod_lo_reg;
    logic [MASS_W-1:0] prod_hi_reg;
    logic [FW-1:0]     fill_reg;
    logic [LW-1:0]     wp_reg;
    result_t           build_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    logic              t_we;
    logic [AW-1:0]     t_waddr, t_raddr;
    logic [MASS_W-1:0] t_wdata, t_rdata;
    logic              p_we;
    logic [LW-1:0]     p_waddr, p_raddr;
    logic [PAY_W-1:0]  p_rdata;

    logic [LW-1:0]     slot_idx;
    logic              slot_ok;
    logic              full;
    logic              empty;
    logic [MASS_W-1:0] pri;
    logic              go_left;
    logic [AW-1:0]     desc_next;
    logic [LW-1:0]     leaf_raw;
    logic [LW-1:0]     leaf_pick;
    logic [AW-1:0]     leaf_parent;
    result_t           disp_build;
    result_t           done_res;

    pstree_ram #(.WIDTH(MASS_W), .DEPTH(2 * LEAVES)) u_tree (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    pstree_ram #(.WIDTH(PAY_W), .DEPTH(LEAVES)) u_pay (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (cur_reg.payload),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign slot_idx    = LW'(cur_reg.slot);
    assign slot_ok     = CMPW'(cur_reg.slot) < CMPW'(fill_reg);
    assign full        = (fill_reg == FW'(CAPACITY));
    assign empty       = (fill_reg == '0);
    assign pri         = (cur_reg.weight > PRI_MAX) ? PRI_MAX : cur_reg.weight;
    assign go_left     = (target_reg <= t_rdata);
    assign desc_next   = {node_reg[AW-2:0], ~go_left};
    assign leaf_raw    = desc_next[LW-1:0];
    assign leaf_pick   = (FW'(leaf_raw) >= fill_reg) ? LW'(fill_reg - FW'(1)) : leaf_raw;
    assign leaf_parent = AW'({1'b1, idx_reg} >> 1);

    always_comb begin
        disp_build = '0;
        if (cur_reg.op == OP_UPDATE || cur_reg.op == OP_READ) begin
            disp_build.bad_index = !slot_ok;
        end
        if (cur_reg.op == OP_READ) begin
            disp_build.found_index = cur_reg.slot;
        end
        done_res            = build_reg;
        done_res.total_mass = root_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid && !out_valid_reg) state_next = ST_DISP;
            ST_DISP: begin
                unique case (cur_reg.op)
                    OP_INSERT:   state_next = ST_LEAF;
                    OP_UPDATE:   state_next = slot_ok ? ST_LEAF : ST_DONE;
                    OP_READ:     state_next = slot_ok ? ST_RDAT : ST_DONE;
                    OP_GET_MASS: state_next = empty ? ST_DONE : ST_DESC;
                    OP_GET_FRAC: state_next = empty ? ST_DONE : ST_FRAC;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_FRAC:  state_next = ST_FSUM;
            ST_FSUM:  state_next = ST_DESC;
            ST_DESC:  if (desc_next[LW]) state_next = ST_RDAT;
            ST_RDAT:  state_next = ST_DONE;
            ST_LEAF:  state_next = ST_UP;
            ST_UP:    if (node_reg == AW'(1)) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop   = 1'b0;
        t_we    = 1'b0;
        t_waddr = clr_reg;
        t_wdata = '0;
        t_raddr = AW'(2);
        p_we    = 1'b0;
        p_waddr = idx_reg;
        p_raddr = idx_reg;
        unique case (state_reg)
            ST_CLEAR: t_we = 1'b1;
            ST_IDLE:  q_pop = q_valid && !out_valid_reg;
            ST_DISP: begin
                if (cur_reg.op == OP_INSERT) begin
                    t_raddr = {1'b1, wp_reg};
                    p_raddr = wp_reg;
                end else if (cur_reg.op == OP_UPDATE || cur_reg.op == OP_READ) begin
                    t_raddr = {1'b1, slot_idx};
                    p_raddr = slot_idx;
                end
            end
            ST_DESC: begin
                if (desc_next[LW]) begin
                    t_raddr = {1'b1, leaf_pick};
                    p_raddr = leaf_pick;
                end else begin
                    t_raddr = {desc_next[AW-2:0], 1'b0};
                end
            end
            ST_LEAF: begin
                t_we    = 1'b1;
                t_waddr = {1'b1, idx_reg};
                t_wdata = pri;
                t_raddr = leaf_parent;
                p_we    = (cur_reg.op == OP_INSERT);
            end
            ST_UP: begin
                t_we    = 1'b1;
                t_waddr = node_reg;
                t_wdata = t_rdata + delta_reg;
                t_raddr = node_reg >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            root_reg      <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == ST_LEAF) begin
                root_reg <= root_reg + (pri - t_rdata);
                if (cur_reg.op == OP_INSERT) begin
                    wp_reg <= (wp_reg == LW'(CAPACITY - 1)) ? '0 : wp_reg + LW'(1);
                    if (!full) begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
            end
            if (state_reg == ST_DONE) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cur_reg <= q_data;
            end
            ST_DISP: begin
                build_reg   <= disp_build;
                node_reg    <= AW'(1);
                target_reg  <= cur_reg.weight;
                idx_reg     <= (cur_reg.op == OP_INSERT) ? wp_reg : slot_idx;
            end
            ST_FRAC: begin
                prod_lo_reg <= 64'(root_reg[31:0]) * 64'(cur_reg.weight[31:0]);
                prod_hi_reg <= MASS_W'(root_reg[47:32]) * MASS_W'(cur_reg.weight[31:0]);
            end
            ST_FSUM: begin
                if (cur_reg.weight[47:32] != '0) begin
                    target_reg <= root_reg;
                end else begin
                    target_reg <= prod_hi_reg + MASS_W'(prod_lo_reg[63:32]);
                end
            end
            ST_DESC: begin
                node_reg <= desc_next;
                if (!go_left) begin
                    target_reg <= target_reg - t_rdata;
                end
                if (desc_next[LW]) begin
                    idx_reg <= leaf_pick;
                end
            end
            ST_RDAT: begin
                build_reg.found_index    <= SLOT_W'(idx_reg);
                build_reg.found_payload  <= p_rdata;
                build_reg.found_priority <= t_rdata[PRI_W-1:0];
            end
            ST_LEAF: begin
                delta_reg <= pri - t_rdata;
                node_reg  <= leaf_parent;
                if (cur_reg.op == OP_INSERT && full) begin
                    build_reg.evicted_valid    <= 1'b1;
                    build_reg.evicted_payload  <= p_rdata;
                    build_reg.evicted_priority <= t_rdata[PRI_W-1:0];
                end
            end
            ST_UP: begin
                node_reg <= node_reg >> 1;
            end
            ST_DONE: begin
                out_reg <= done_res;
            end
            default: ;
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ tb/sv/pstree_checker.sv @@
// Checker for the prioritized sum-tree sampler: predicts each result and compares.
module pstree_checker
    import pstree_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending
);

    localparam int LEAVES = 1024;
    localparam logic [MASS_W-1:0] PRI_MAX = (48'd1 << PRI_W) - 48'd1;

    logic [MASS_W-1:0] sums [1:2*LEAVES-1];
    logic [PAY_W-1:0]  handles [0:LEAVES-1];
    logic [SLOT_W-1:0] wr_ptr;
    int                filled;
    result_t           expected_results [$];

    task automatic write_leaf(input int idx, input logic [MASS_W-1:0] pri);
        int                node;
        logic [MASS_W-1:0] delta;
        node = LEAVES + idx;
        delta = pri - sums[node];
        sums[node] = pri;
        while (node > 1) begin
            node = node >> 1;
            sums[node] = sums[node] + delta;
        end
    endtask

    function automatic int walk_down(input logic [MASS_W-1:0] target);
        int node;
        node = 1;
        while (node < LEAVES) begin
            if (target <= sums[2*node]) begin
                node = 2*node;
            end else begin
                target = target - sums[2*node];
                node = 2*node + 1;
            end
        end
        return node - LEAVES;
    endfunction

    task automatic apply_request(input logic [2:0] kind, input logic [SLOT_W-1:0] slot,
                                 input logic [MASS_W-1:0] weight,
                                 input logic [PAY_W-1:0] handle, output result_t res);
        logic [MASS_W-1:0] pri;
        logic [MASS_W-1:0] target;
        logic [95:0]       prod;
        int                leaf;
        res = '0;
        pri = (weight > PRI_MAX) ? PRI_MAX : weight;
        case (kind)
            REQ_INSERT: begin
                if (filled >= LEAVES) begin
                    res.evicted_valid = 1'b1;
                    res.evicted_payload = handles[wr_ptr];
                    res.evicted_priority = sums[LEAVES + wr_ptr][PRI_W-1:0];
                end
                handles[wr_ptr] = handle;
                write_leaf(int'(wr_ptr), pri);
                wr_ptr = wr_ptr + 1'b1;
                if (filled < LEAVES) filled++;
            end
            REQ_UPDATE: begin
                if (slot < filled) write_leaf(int'(slot), pri);
                else res.bad_index = 1'b1;
            end
            REQ_GET_MASS, REQ_GET_FRAC: begin
                if (filled > 0) begin
                    if (kind == REQ_GET_MASS) begin
                        target = weight;
                    end else if (weight >= 48'h1_0000_0000) begin
                        target = sums[1];
                    end else begin
                        prod = {48'd0, sums[1][47:32]} * {48'd0, weight}
                             + (({64'd0, sums[1][31:0]} * {48'd0, weight}) >> 32);
                        target = prod[MASS_W-1:0];
                    end
                    leaf = walk_down(target);
                    if (leaf >= filled) leaf = filled - 1;
                    res.found_index = leaf[SLOT_W-1:0];
                    res.found_payload = handles[leaf];
                    res.found_priority = sums[LEAVES + leaf][PRI_W-1:0];
                end
            end
            REQ_READ: begin
                res.found_index = slot;
                if (slot < filled) begin
                    res.found_payload = handles[slot];
                    res.found_priority = sums[LEAVES + slot][PRI_W-1:0];
                end else begin
                    res.bad_index = 1'b1;
                end
            end
            default: ;
        endcase
        res.total_mass = sums[1];
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (fail_count < 10)
                $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        wr_ptr = '0;
        filled = 0;
        for (int i = 1; i < 2*LEAVES; i++) sums[i] = '0;
        for (int i = 0; i < LEAVES; i++) handles[i] = '0;
    end

    always @(posedge aclk) begin
        result_t exp_r;
        result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.evicted_payload = m_axis_tdata[31:0];
            got.evicted_priority = m_axis_tdata[63:32];
            got.found_index = m_axis_tdata[73:64];
            got.found_payload = m_axis_tdata[105:74];
            got.found_priority = m_axis_tdata[137:106];
            got.total_mass = m_axis_tdata[185:138];
            got.evicted_valid = m_axis_tuser[0];
            got.bad_index = m_axis_tuser[1];
            if (expected_results.size() == 0) begin
                if (fail_count < 10) $display("unexpected result beat");
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("evicted_valid", exp_r.evicted_valid, got.evicted_valid);
                check_field("evicted_payload", exp_r.evicted_payload, got.evicted_payload);
                check_field("evicted_priority", exp_r.evicted_priority,
                            got.evicted_priority);
                check_field("found_index", exp_r.found_index, got.found_index);
                check_field("found_payload", exp_r.found_payload, got.found_payload);
                check_field("found_priority", exp_r.found_priority, got.found_priority);
                check_field("total_mass", exp_r.total_mass, got.total_mass);
                check_field("bad_index", exp_r.bad_index, got.bad_index);
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            apply_request(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[57:10],
                          s_axis_tdata[89:58], exp_r);
            expected_results.push_back(exp_r);
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sum-tree sampler testbench: clock, reset, stimulus and verdict.
module testbench;
    import pstree_pkg::*;

    localparam int LIMIT = 2000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           filled = 0;
    int           cycles = 0;
    bit           long_hold = 1'b0;

    always #4 aclk = ~aclk;

    prioritized_sum_tree_sampler_core u_top (.*);

    pstree_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_beat(input logic [2:0] kind, input logic [9:0] slot,
                             input logic [47:0] weight, input logic [31:0] handle);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, handle, weight, slot};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        if (kind == REQ_INSERT && filled < 1024) filled++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    function automatic logic [9:0] pick_slot();
        if (filled > 0 && $urandom_range(99) < 85) return 10'($urandom_range(filled - 1));
        return 10'($urandom_range(1023));
    endfunction

    function automatic logic [47:0] pick_priority();
        case ($urandom_range(3))
            0: return rand48();
            1: return {16'd0, $urandom};
            2: return 48'($urandom_range(65535));
            default: return 48'($urandom_range(1048575));
        endcase
    endfunction

    task automatic random_beat(input int insert_pct);
        int x;
        if ($urandom_range(99) < insert_pct) begin
            send_beat(REQ_INSERT, 10'($urandom_range(1023)), pick_priority(), $urandom);
            return;
        end
        x = $urandom_range(19);
        if (x < 5)
            send_beat(REQ_UPDATE, pick_slot(), pick_priority(), $urandom);
        else if (x < 10)
            send_beat(REQ_GET_MASS, 10'($urandom_range(1023)),
                      rand48() >> $urandom_range(47), $urandom);
        else if (x < 15)
            send_beat(REQ_GET_FRAC, 10'($urandom_range(1023)),
                      ($urandom_range(9) == 0) ? rand48() : {16'd0, $urandom}, $urandom);
        else if (x < 19)
            send_beat(REQ_READ, pick_slot(), rand48(), $urandom);
        else
            send_beat(3'($urandom_range(7, 5)), 10'($urandom_range(1023)), rand48(),
                      $urandom);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_beat(REQ_GET_MASS, 10'd0, 48'd5, 32'd0);
        send_beat(REQ_GET_FRAC, 10'd0, 48'h8000_0000, 32'd0);
        send_beat(REQ_READ, 10'd1023, 48'd0, 32'd0);
        send_beat(REQ_UPDATE, 10'd0, 48'd7, 32'd0);
        send_beat(3'd5, 10'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(3'd7, 10'd0, 48'd0, 32'd0);
        send_beat(REQ_INSERT, 10'd0, 48'd0, 32'd0);
        send_beat(REQ_INSERT, 10'h3FF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(REQ_INSERT, 10'd0, 48'h1_0000, 32'h1234_5678);
        send_beat(REQ_INSERT, 10'd0, 48'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_beat(REQ_UPDATE, 10'd2, 48'h2_0000, 32'd0);
        send_beat(REQ_UPDATE, 10'd4, 48'd9, 32'd0);
        send_beat(REQ_UPDATE, 10'd1023, 48'd9, 32'd0);
        send_beat(REQ_GET_MASS, 10'd0, 48'd0, 32'd0);
        send_beat(REQ_GET_MASS, 10'd0, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_beat(REQ_GET_FRAC, 10'd0, 48'd0, 32'd0);
        send_beat(REQ_GET_FRAC, 10'd0, 48'h1_0000_0000, 32'd0);
        send_beat(REQ_GET_FRAC, 10'd0, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_beat(REQ_GET_FRAC, 10'd0, 48'hFFFF_FFFF, 32'd0);
        send_beat(REQ_READ, 10'd0, 48'd0, 32'd0);
        send_beat(REQ_READ, 10'd3, 48'd0, 32'd0);
        send_beat(REQ_READ, 10'd4, 48'd0, 32'd0);
        for (int i = 0; i < 650; i++) random_beat(95);
        for (int phase = 1; phase < 4; phase++) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
            wait (pending == 0);
            send_idle_pct = (phase == 2) ? 0 : ((phase == 1) ? 57 : 35);
            stall_pct = (phase == 1) ? 0 : ((phase == 2) ? 57 : 35);
            if (phase == 2) long_hold = 1'b1;
            for (int i = 0; i < 300; i++) random_beat(55);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
